[sv/tqm_pkg.sv]
// shared types, constants and tables of the tile quad mesh generator
package tqm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_PRESENT_CODE = 2'd1;
  localparam logic [1:0] CFG_FILL_ALL     = 2'd2;

  localparam int unsigned MAX_WIDTH = 1024;

  // only the low 12 bits of the seed product matter
  localparam logic [11:0] COL_MUL     = 12'd87;
  localparam logic [11:0] SEED_MUL_LO = 12'(48271 % 4096);

  localparam int unsigned VERTS_PER_TILE   = 4;
  localparam int unsigned RESULTS_PER_TILE = 10;
  localparam logic [3:0]  STEP_LAST        = 4'(RESULTS_PER_TILE - 1);

  localparam logic ITEM_VERTEX = 1'b0;
  localparam logic ITEM_INDEX  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [7:0]  seed;
    logic [21:0] base;
  } tqm_tile_t;

  typedef struct packed {
    logic        item_kind;
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic        tex_u;
    logic        tex_v;
    logic [9:0]  tile_col;
    logic [9:0]  tile_row;
    logic [7:0]  tile_seed;
    logic [21:0] index_value;
    logic        last;
  } tqm_result_t;

  // triangle corner order 0,2,1,1,2,3
  function automatic logic [1:0] tri_offset(input logic [2:0] idx);
    logic [1:0] off;
    case (idx)
      3'd0:    off = 2'd0;
      3'd1:    off = 2'd2;
      3'd2:    off = 2'd1;
      3'd3:    off = 2'd1;
      3'd4:    off = 2'd2;
      3'd5:    off = 2'd3;
      default: off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

[sv/tile_quad_mesh_generator_core.sv]
// top level of the tile quad mesh generator
//
// Cell codes of a tile map enter in row-major order on the in_ queue port
// (in_push / in_full). A present cell becomes ten results on the out_ queue
// port (out_empty / out_pop): four corner vertices, then six triangle indices,
// the last with out_last set. Absent cells and cells past the row bound give
// nothing but are still accepted.
// The front end takes one cell per cycle while in_full is low and writes a tile
// descriptor into a four-entry queue; the back end sends one result per cycle
// from it while out_pop frees the output register, so a present cell gives ten results.
// in_full rises only when the queue holds four waiting tiles.
// A tile passes through the queue and the current tile register into the result
// register before its first result shows. When out_pop stays low the result register
// holds and the queue fills, after which in_full backs up the input.
// The cfg_ port is always ready; the user must write registers only while idle, which the block does not enforce.
// Reset clears counters, queue and output register and loads grid width 1,
// present code 0 and fill-all off.
module tile_quad_mesh_generator_core import tqm_pkg::*; #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_cell_code,
  input  logic        in_restart,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_item_kind,
  output logic [10:0] out_pos_x,
  output logic [10:0] out_pos_y,
  output logic        out_tex_u,
  output logic        out_tex_v,
  output logic [9:0]  out_tile_col,
  output logic [9:0]  out_tile_row,
  output logic [7:0]  out_tile_seed,
  output logic [21:0] out_index_value,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic        accept;
  logic        tile_we;
  tqm_tile_t   tile_in, tile_out;
  logic        q_full, q_empty, q_pop;
  logic        out_valid;
  tqm_result_t res;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  tqm_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cell_code (in_cell_code),
    .restart   (in_restart),
    .tile_we   (tile_we),
    .tile      (tile_in)
  );

  tqm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tile_we),
    .wr_data (tile_in),
    .rd_en   (q_pop),
    .rd_data (tile_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  tqm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (tile_out),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_empty       = !out_valid;
  assign out_item_kind   = res.item_kind;
  assign out_pos_x       = res.pos_x;
  assign out_pos_y       = res.pos_y;
  assign out_tex_u       = res.tex_u;
  assign out_tex_v       = res.tex_v;
  assign out_tile_col    = res.tile_col;
  assign out_tile_row    = res.tile_row;
  assign out_tile_seed   = res.tile_seed;
  assign out_index_value = res.index_value;
  assign out_last        = res.last;

endmodule

[sv/tqm_front.sv]
// front end: configuration, map position counters, cell classification and seed
module tqm_front import tqm_pkg::*; #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [10:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] cell_code,
  input  logic       restart,
  output logic       tile_we,
  output tqm_tile_t  tile
);

  localparam int unsigned ROW_BOUND = (MAX_SIDE < MAX_WIDTH) ? MAX_SIDE : MAX_WIDTH;
  localparam logic [9:0]  ROW_LAST  = 10'(ROW_BOUND - 1);

  logic [9:0]  wm1_r, wm1_nxt;
  logic [7:0]  code_r, code_nxt;
  logic        fill_r, fill_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [9:0]  row_r, row_nxt;
  logic [11:0] col87_r, col87_nxt;
  logic [20:0] tcnt_r, tcnt_nxt;
  logic        end_r, end_nxt;

  logic [9:0]  cur_col, cur_row;
  logic [11:0] cur_col87;
  logic [20:0] cur_tcnt;
  logic        cur_end;
  logic        live, present;
  logic [11:0] seed_sum, seed_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r   <= '0;
      code_r  <= '0;
      fill_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      col87_r <= '0;
      tcnt_r  <= '0;
      end_r   <= 1'b0;
    end else begin
      wm1_r   <= wm1_nxt;
      code_r  <= code_nxt;
      fill_r  <= fill_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      col87_r <= col87_nxt;
      tcnt_r  <= tcnt_nxt;
      end_r   <= end_nxt;
    end
  end

  // width is clamped to 1..1024 when written and kept as width minus one
  always_comb begin
    wm1_nxt  = wm1_r;
    code_nxt = code_r;
    fill_nxt = fill_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH: begin
          if (cfg_data == 11'd0) wm1_nxt = 10'd0;
          else if (cfg_data > 11'(MAX_WIDTH)) wm1_nxt = 10'(MAX_WIDTH - 1);
          else wm1_nxt = 10'(cfg_data - 11'd1);
        end
        CFG_PRESENT_CODE: code_nxt = cfg_data[7:0];
        CFG_FILL_ALL:     fill_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cur_col   = restart ? '0 : col_r;
  assign cur_row   = restart ? '0 : row_r;
  assign cur_col87 = restart ? '0 : col87_r;
  assign cur_tcnt  = restart ? '0 : tcnt_r;
  assign cur_end   = restart ? 1'b0 : end_r;

  assign live    = accept && !cur_end;
  assign present = fill_r || (cell_code == code_r);

  // col87 tracks 87*col mod 4096, so one multiplier makes the seed
  assign seed_sum  = {2'b00, cur_row} + cur_col87;
  assign seed_prod = seed_sum * SEED_MUL_LO;

  assign tile_we   = live && present;
  assign tile.col  = cur_col;
  assign tile.row  = cur_row;
  assign tile.seed = seed_prod[11:4];
  assign tile.base = {cur_tcnt[19:0], 2'b00};

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    col87_nxt = col87_r;
    tcnt_nxt  = tcnt_r;
    end_nxt   = end_r;
    if (accept) begin
      col_nxt   = cur_col;
      row_nxt   = cur_row;
      col87_nxt = cur_col87;
      tcnt_nxt  = cur_tcnt;
      end_nxt   = cur_end;
      if (live) begin
        if (present) tcnt_nxt = cur_tcnt + 21'd1;
        // a column left beyond a narrowed width wraps as well
        if (cur_col >= wm1_r) begin
          col_nxt   = '0;
          col87_nxt = '0;
          if (cur_row == ROW_LAST) end_nxt = 1'b1;
          else row_nxt = cur_row + 10'd1;
        end else begin
          col_nxt   = cur_col + 10'd1;
          col87_nxt = cur_col87 + COL_MUL;
        end
      end
    end
  end

endmodule

[sv/tqm_fifo.sv]
// short tile descriptor queue between front and back end
module tqm_fifo import tqm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  tqm_tile_t wr_data,
  input  logic      rd_en,
  output tqm_tile_t rd_data,
  output logic      full,
  output logic      empty
);

  tqm_tile_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr_r] <= wr_data;
  end

endmodule

[sv/tqm_back.sv]
// back end: steps through the ten results of a tile into an output register
module tqm_back import tqm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  tqm_tile_t   q_data,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_valid,
  output tqm_result_t out_res
);

  tqm_tile_t   cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  tqm_result_t res_r, res_nxt;
  tqm_result_t gen;
  logic        adv, fin;
  logic [2:0]  idx;

  assign idx = 3'(step_r - 4'(VERTS_PER_TILE));

  always_comb begin
    gen = '0;
    if (step_r < 4'(VERTS_PER_TILE)) begin
      gen.item_kind = ITEM_VERTEX;
      gen.tex_u     = step_r[0];
      gen.tex_v     = step_r[1];
      gen.pos_x     = {1'b0, cur_r.col} + {10'd0, step_r[0]};
      gen.pos_y     = {1'b0, cur_r.row} + {10'd0, step_r[1]};
      gen.tile_col  = cur_r.col;
      gen.tile_row  = cur_r.row;
      gen.tile_seed = cur_r.seed;
    end else begin
      gen.item_kind   = ITEM_INDEX;
      gen.index_value = cur_r.base + {20'd0, tri_offset(idx)};
      gen.last        = (step_r == STEP_LAST);
    end
  end

  assign adv   = cur_valid_r && (!out_valid_r || out_pop);
  assign fin   = adv && (step_r == STEP_LAST);
  assign q_pop = (!cur_valid_r || fin) && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) out_valid_nxt = 1'b0;
    if (adv) begin
      res_nxt       = gen;
      out_valid_nxt = 1'b1;
      step_nxt      = step_r + 4'd1;
    end
    if (fin) cur_valid_nxt = 1'b0;
    // next tile is picked up in the same cycle the last result leaves
    if (q_pop) begin
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

[sv/tqm_checker.sv]
// port-level checks of the tile quad mesh generator, bound to the top level
module tqm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_item_kind,
  input logic [10:0] out_pos_x,
  input logic [9:0]  out_tile_col,
  input logic        out_tex_u,
  input logic [7:0]  out_tile_seed,
  input logic [21:0] out_index_value,
  input logic        out_last
);

  // reset leaves both queues empty
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_index_value) && $stable(out_pos_x))
    else $error("waiting result changed");

  // vertex x is tile column plus its u corner
  a_vertex_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_item_kind |->
      out_pos_x == (11'(out_tile_col) + 11'(out_tex_u)) && out_index_value == 22'd0 && !out_last)
    else $error("vertex record inconsistent");

  a_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item_kind |-> out_pos_x == 11'd0 && out_tile_seed == 8'd0)
    else $error("index record carries vertex data");

  // the closing index is base plus three, base a multiple of four
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_last |-> out_item_kind && out_index_value[1:0] == 2'd3)
    else $error("last flag on wrong record");

endmodule

bind tile_quad_mesh_generator_core tqm_checker u_tqm_checker (.*);

[dv/tb_tile_quad_mesh_generator_core.sv]
// testbench for the tile quad mesh generator: queued cell stimulus, mesh prediction, result checks
`timescale 1ns / 100ps

module tb_tile_quad_mesh_generator_core;
  import tqm_pkg::*;

  localparam int unsigned MAP_SIDE      = 1024;
  localparam int unsigned ROW_BOUND     = (MAP_SIDE < 1024) ? MAP_SIDE : 1024;
  localparam logic [31:0] HASH_COL_MUL  = 32'd87;
  localparam logic [31:0] HASH_MUL      = 32'd48271;
  localparam int unsigned CORNERS       = 4;
  localparam int unsigned TRI_INDEXES   = 6;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_CELLS   = 32;

  // corner order of the two triangles of a quad
  localparam int unsigned TRI_CORNER [TRI_INDEXES] = '{0, 2, 1, 1, 2, 3};

  typedef struct packed {
    logic [7:0] code;
    logic       restart;
  } map_cell_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_cell_code = 8'd0;
  logic        in_restart = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_item_kind;
  logic [10:0] out_pos_x;
  logic [10:0] out_pos_y;
  logic        out_tex_u;
  logic        out_tex_v;
  logic [9:0]  out_tile_col;
  logic [9:0]  out_tile_row;
  logic [7:0]  out_tile_seed;
  logic [21:0] out_index_value;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_GRID_WIDTH;
  logic [10:0] cfg_data = 11'd0;

  tile_quad_mesh_generator_core #(
    .MAX_SIDE (MAP_SIDE)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cell_code    (in_cell_code),
    .in_restart      (in_restart),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_item_kind   (out_item_kind),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_tile_col    (out_tile_col),
    .out_tile_row    (out_tile_row),
    .out_tile_seed   (out_tile_seed),
    .out_index_value (out_index_value),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // mesh predictor state and its copy of the registers
  logic [10:0] mdl_width = 11'd1;
  logic [7:0]  mdl_code = 8'd0;
  logic        mdl_fill = 1'b0;
  logic [9:0]  mdl_col = '0;
  logic [9:0]  mdl_row = '0;
  logic [20:0] mdl_tiles = '0;
  logic        mdl_done = 1'b0;

  map_cell_t   cell_queue [$];
  tqm_result_t mesh_expect [$];

  bit          cell_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned pop_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned cells_sent = 0;
  int unsigned tiles_predicted = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;

  function automatic int unsigned map_width();
    if (mdl_width == 11'd0) return 1;
    if (mdl_width > 11'd1024) return 1024;
    return int'(mdl_width);
  endfunction

  task automatic predict_mesh(input logic [7:0] code, input logic restart);
    logic [31:0] hash;
    logic [7:0]  seed;
    logic [21:0] base;
    tqm_result_t r;
    if (restart) begin
      mdl_col   = '0;
      mdl_row   = '0;
      mdl_tiles = '0;
      mdl_done  = 1'b0;
    end
    if (!mdl_done) begin
      if (mdl_fill || code == mdl_code) begin
        hash = (32'(mdl_row) + HASH_COL_MUL * 32'(mdl_col)) * HASH_MUL;
        seed = hash[11:4];
        base = {mdl_tiles[19:0], 2'b00};
        for (int k = 0; k < CORNERS; k++) begin
          r             = '0;
          r.item_kind   = ITEM_VERTEX;
          r.pos_x       = 11'(mdl_col) + 11'(k % 2);
          r.pos_y       = 11'(mdl_row) + 11'(k / 2);
          r.tex_u       = k[0];
          r.tex_v       = k[1];
          r.tile_col    = mdl_col;
          r.tile_row    = mdl_row;
          r.tile_seed   = seed;
          mesh_expect.push_back(r);
        end
        for (int k = 0; k < TRI_INDEXES; k++) begin
          r             = '0;
          r.item_kind   = ITEM_INDEX;
          r.index_value = base + 22'(TRI_CORNER[k]);
          r.last        = (k == TRI_INDEXES - 1);
          mesh_expect.push_back(r);
        end
        mdl_tiles = mdl_tiles + 21'd1;
        tiles_predicted++;
      end
      if (int'(mdl_col) + 1 >= map_width()) begin
        mdl_col = '0;
        if (int'(mdl_row) + 1 >= ROW_BOUND) mdl_done = 1'b1;
        else mdl_row = mdl_row + 10'd1;
      end else begin
        mdl_col = mdl_col + 10'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  task automatic queue_cell(input logic [7:0] code, input logic restart);
    map_cell_t mc;
    mc.code    = code;
    mc.restart = restart;
    cell_queue.push_back(mc);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GRID_WIDTH:   mdl_width = data;
      CFG_PRESENT_CODE: mdl_code  = data[7:0];
      CFG_FILL_ALL:     mdl_fill  = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // absent cells give no results, so let the pipeline drain a little longer
  task automatic wait_idle();
    while (cell_queue.size() != 0 || mesh_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input transaction capture and result check
  always @(posedge clk) begin
    tqm_result_t exp_r;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_mesh(in_cell_code, in_restart);
        cells_sent++;
        cell_taken = 1'b1;
      end
      if (out_pop && !out_empty) begin
        if (mesh_expect.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count++;
        end else begin
          exp_r = mesh_expect.pop_front();
          check_field("item_kind", exp_r.item_kind, out_item_kind);
          check_field("pos_x", exp_r.pos_x, out_pos_x);
          check_field("pos_y", exp_r.pos_y, out_pos_y);
          check_field("tex_u", exp_r.tex_u, out_tex_u);
          check_field("tex_v", exp_r.tex_v, out_tex_v);
          check_field("tile_col", exp_r.tile_col, out_tile_col);
          check_field("tile_row", exp_r.tile_row, out_tile_row);
          check_field("tile_seed", exp_r.tile_seed, out_tile_seed);
          check_field("index_value", exp_r.index_value, out_index_value);
          check_field("last", exp_r.last, out_last);
          results_checked++;
        end
      end
    end
  end

  // cell driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (cell_taken) begin
      cell_taken = 1'b0;
      cell_queue.delete(0);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
    if (!rst_n || gap_left > 0 || cell_queue.size() == 0) begin
      in_push <= 1'b0;
      if (rst_n && gap_left > 0) gap_left--;
    end else begin
      in_push      <= 1'b1;
      in_cell_code <= cell_queue[0].code;
      in_restart   <= cell_queue[0].restart;
    end
  end

  // result receiver: pop runs and stalls, now and then a long stall to fill the queue
  always @(negedge clk) begin
    if (pop_left > 0) begin
      out_pop <= 1'b1;
      pop_left--;
    end else if (stall_left > 0) begin
      out_pop <= 1'b0;
      stall_left--;
    end else begin
      out_pop    <= 1'b1;
      pop_left   = $urandom_range(0, 23);
      case ($urandom_range(0, 7))
        0:       stall_left = $urandom_range(20, 40);
        1, 2:    stall_left = 0;
        default: stall_left = $urandom_range(1, 8);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout: %0d results still expected after %0d cycles",
               mesh_expect.size(), cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0]  code;
    logic [7:0]  hit_code;
    logic [10:0] width;
    logic        fill;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: width 1, code 0, no fill
    queue_cell(8'h00, 1'b0);
    queue_cell(8'hFF, 1'b0);
    queue_cell(8'h00, 1'b0);
    queue_cell(8'h00, 1'b1);
    wait_idle();

    // upper data bits of the code register are junk
    write_reg(CFG_GRID_WIDTH, 11'd3);
    write_reg(CFG_PRESENT_CODE, 11'h7A5);
    write_reg(CFG_FILL_ALL, 11'h000);
    queue_cell(8'hA5, 1'b1);
    queue_cell(8'h5A, 1'b0);
    queue_cell(8'hA5, 1'b0);
    queue_cell(8'hA5, 1'b0);
    queue_cell(8'hA5, 1'b1);
    queue_cell(8'h00, 1'b0);
    wait_idle();

    // width zero behaves as one, rectangle fill
    write_reg(CFG_GRID_WIDTH, 11'd0);
    write_reg(CFG_FILL_ALL, 11'h7FF);
    queue_cell(8'h00, 1'b0);
    queue_cell(8'hFF, 1'b0);
    queue_cell(8'h5A, 1'b0);
    wait_idle();

    // width above the maximum clips
    write_reg(CFG_GRID_WIDTH, 11'd2047);
    write_reg(CFG_PRESENT_CODE, 11'h0FF);
    write_reg(CFG_FILL_ALL, 11'h7FE);
    queue_cell(8'hFF, 1'b1);
    queue_cell(8'hFF, 1'b0);
    queue_cell(8'h00, 1'b0);
    queue_cell(8'hFF, 1'b0);
    wait_idle();

    // walk one column down a few dozen rows, then restart
    write_reg(CFG_GRID_WIDTH, 11'd1);
    write_reg(CFG_PRESENT_CODE, 11'h03C);
    for (int i = 0; i < 40; i++) begin
      if (i >= 36 || i % 7 == 5) begin
        code = 8'h3C;
      end else begin
        code = 8'($urandom_range(0, 255));
        if (code == 8'h3C) code = 8'h3D;
      end
      queue_cell(code, i == 0);
    end
    queue_cell(8'h3C, 1'b1);
    queue_cell(8'h3C, 1'b0);
    wait_idle();

    // a row wide enough that 87*col passes 4096, then wrap into the next row
    write_reg(CFG_GRID_WIDTH, 11'd60);
    write_reg(CFG_PRESENT_CODE, 11'h0C3);
    for (int i = 0; i < 64; i++) begin
      if (i >= 56 || i % 13 == 7) begin
        code = 8'hC3;
      end else begin
        code = 8'($urandom_range(0, 255));
        if (code == 8'hC3) code = 8'hC2;
      end
      queue_cell(code, i == 0);
    end
    wait_idle();

    // random settings, mostly present cells with a few restarts
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       width = 11'd0;
        1:       width = 11'd1;
        2:       width = 11'd2;
        3:       width = 11'd3;
        4:       width = 11'($urandom_range(4, 12));
        5:       width = 11'd1024;
        6:       width = 11'($urandom_range(1025, 2047));
        default: width = 11'($urandom_range(0, 2047));
      endcase
      hit_code = 8'($urandom_range(0, 255));
      fill     = ($urandom_range(0, 2) == 0);
      write_reg(CFG_GRID_WIDTH, width);
      write_reg(CFG_PRESENT_CODE, {3'($urandom_range(0, 7)), hit_code});
      write_reg(CFG_FILL_ALL, {10'($urandom_range(0, 1023)), fill});
      for (int i = 0; i < PHASE_CELLS; i++) begin
        code = ($urandom_range(0, 1) == 0) ? hit_code : 8'($urandom_range(0, 255));
        queue_cell(code, 1'((i == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 24) == 0)));
      end
      wait_idle();
    end

    $display("covered %0d cells in %0d register writes, predicted %0d tiles",
             cells_sent, reg_writes, tiles_predicted);
    $display("checked %0d result transactions with %0d mismatches",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
